// ----- design/tppt_pkg.sv -----
// shared types and constants for the tick period and phase tracker
package tppt_pkg;

   // fixed widths of the configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRE_OFFSET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETRY_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ALIGN  = 2'd2;

   // period word has this many integer bits ahead of the fraction
   localparam int PERIOD_INT_BITS = 16;

   // period limits and reset value in whole microseconds
   localparam int unsigned PERIOD_MIN_US   = 4000;
   localparam int unsigned PERIOD_MAX_US   = 40000;
   localparam int unsigned PERIOD_RESET_US = 15625;

   // fallback tick and retry nudge in microseconds
   localparam int unsigned DEFAULT_TICK_US = 15625;
   localparam int unsigned RETRY_NUDGE_US  = 100;

   // longest plausible gap (40 periods at the largest period)
   localparam int          GAP_W      = 21;
   localparam int unsigned GAP_CAP_US = 1600000;

   // offset and retry clamps
   localparam logic [14:0] OFFSET_MAX_US = 15'd20000;
   localparam logic [2:0]  RETRY_MIN     = 3'd1;
   localparam logic [2:0]  RETRY_MAX     = 3'd4;

   // accepted gaps needed for lock
   localparam logic [2:0] LOCK_COUNT = 3'd4;

   // tick count of one gap stays below 64, so six quotient bits suffice
   localparam int N_STEPS = 6;
   localparam int NW      = 6;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OBS_EVAL,
      ST_SCHED_PREP,
      ST_SCHED_EVAL,
      ST_BLEND_OPS,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_REPLY
   } tppt_state_type;

   // what the running division is for
   typedef enum logic [1:0] {
      JOB_TICKS,
      JOB_BLEND,
      JOB_PHASE
   } div_job_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- design/tppt_div.sv -----
// shared restoring divider, one quotient bit per cycle
module tppt_div
   import tppt_pkg::*;
#(
   parameter int DVD_W = 45,
   parameter int DVS_W = 21
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [$clog2(DVD_W+1)-1:0] steps,
   input  logic [DVS_W-1:0]           rem_init,
   input  logic [DVD_W-1:0]           bits_init,
   input  logic [DVS_W-1:0]           divisor,
   output logic [DVD_W-1:0]           quotient,
   output logic [DVS_W-1:0]           remainder,
   output div_status_type             status
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] bits_ff, bits_in;
   logic [DVS_W-1:0] den_ff, den_in;

   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;

   // trial subtract of the shifted partial remainder
   assign trial = {rem_ff, bits_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   // load on start, otherwise step while the count runs
   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      bits_in = bits_ff;
      den_in  = den_ff;
      if (start) begin
         cnt_in  = steps;
         rem_in  = rem_init;
         bits_in = bits_init;
         den_in  = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
         rem_in  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         bits_in = {bits_ff[DVD_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      den_ff  <= den_in;
   end

   assign quotient    = bits_ff;
   assign remainder   = rem_ff;
   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;

   // a new division never starts over a running one
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !status.busy)
      else $error("divider started while busy");

   // done comes only after the last step
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      status.done |-> (cnt_ff == '0) && $past(cnt_ff == CNT_W'(1)))
      else $error("divider done without a final step");

endmodule

// ----- design/tick_period_phase_tracker.sv -----
// tick period and phase tracker top level: sequencer, state and shared divider
// sequence: an observe that is rejected goes from evaluation straight to its result word; one that
//   refines the period runs two divisions (6 and 17+PERIOD_FRAC_BITS steps)
// sequence: a grid-aligned schedule runs a phase division of TIME_WIDTH+1+PERIOD_FRAC_BITS steps
//   when the grid is valid and the anchor is not after the reference time, and none otherwise
// throughput: one word at a time, set by the single shared divider; next word taken on return to idle
// reset: synchronous, clears the grid, restores the default period and registers, ready at once
module tick_period_phase_tracker
   import tppt_pkg::*;
#(
   parameter int TIME_WIDTH       = 40,
   parameter int PERIOD_FRAC_BITS = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_type,
   input  logic [TIME_WIDTH-1:0]                 req_time_us,
   input  logic                                  req_retry_schedule,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [TIME_WIDTH:0]                   rsp_fire_time_us,
   output logic [PERIOD_INT_BITS+PERIOD_FRAC_BITS-1:0] rsp_period_q4,
   output logic                                  rsp_locked,
   output logic                                  rsp_gap_accepted,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [CSR_INDEX_W-1:0]                csr_index,
   input  logic [CSR_DATA_W-1:0]                 csr_wdata
);

   localparam int TW     = TIME_WIDTH;
   localparam int PFB    = PERIOD_FRAC_BITS;
   localparam int PW     = PERIOD_INT_BITS + PFB;
   localparam int FW     = TW + 1;
   localparam int QW     = TW + 1 + PFB;
   localparam int SW     = QW + 1;
   localparam int DVS_W  = PW + 1;
   localparam int DTQ_W  = GAP_W + PFB;
   localparam int CMP_W  = DTQ_W + 6;
   localparam int XN_W   = DTQ_W + 2;
   localparam int BW     = PW + NW + 4;
   localparam int EW     = PW + 3;
   localparam int CNT_W  = $clog2(QW + 1);
   localparam int BLEND_STEPS = PW + 1;

   localparam logic [PW-1:0] PERIOD_MIN_Q   = PW'(PERIOD_MIN_US) << PFB;
   localparam logic [PW-1:0] PERIOD_MAX_Q   = PW'(PERIOD_MAX_US) << PFB;
   localparam logic [PW-1:0] PERIOD_RESET_Q = PW'(PERIOD_RESET_US) << PFB;
   localparam logic [EW-1:0] HALF_Q         = EW'((1 << PFB) >> 1);

   // sequencer and job
   tppt_state_type state_ff, state_in;
   div_job_type    job_ff, job_in;

   // configuration registers
   logic [CSR_DATA_W-1:0] fire_offset_ff, fire_offset_in;
   logic [2:0]            retry_ticks_ff, retry_ticks_in;
   logic                  align_en_ff, align_en_in;

   // tracker state
   logic          grid_valid_ff, grid_valid_in;
   logic          converged_ff, converged_in;
   logic [PW-1:0] period_ff, period_in;
   logic [TW-1:0] anchor_ff, anchor_in;
   logic [TW-1:0] last_ff, last_in;
   logic [2:0]    count_ff, count_in;

   // working registers of the current word
   logic [TW-1:0]    t_ff, t_in;
   logic             retry_ff, retry_in;
   logic [DTQ_W-1:0] dtq_ff, dtq_in;
   logic [NW-1:0]    n_ff, n_in;
   logic [FW-1:0]    ref_ff, ref_in;
   logic [EW-1:0]    extra_ff, extra_in;
   logic [SW-1:0]    base_ff, base_in;
   logic [FW-1:0]    fire_ff, fire_in;
   logic             gap_ff, gap_in;

   // divider operands
   logic [CNT_W-1:0] dv_steps_ff, dv_steps_in;
   logic [DVS_W-1:0] dv_rem_ff, dv_rem_in;
   logic [QW-1:0]    dv_bits_ff, dv_bits_in;
   logic [DVS_W-1:0] dv_den_ff, dv_den_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0] rsp_fire_ff, rsp_fire_in;
   logic [PW-1:0] rsp_period_ff, rsp_period_in;
   logic          rsp_locked_ff, rsp_locked_in;
   logic          rsp_gap_ff, rsp_gap_in;

   // fsm outputs
   logic req_take;
   logic div_start;
   logic reply_take;

   // divider
   logic [QW-1:0]    div_quotient;
   logic [DVS_W-1:0] div_remainder;
   div_status_type   div_status;

   tppt_div #(
      .DVD_W (QW),
      .DVS_W (DVS_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .steps     (dv_steps_ff),
      .rem_init  (dv_rem_ff),
      .bits_init (dv_bits_ff),
      .divisor   (dv_den_ff),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_status)
   );

   // gap plausibility checks
   logic [TW-1:0]    dt;
   logic             obs_backwards, obs_too_long, obs_short, obs_long, obs_reject;
   logic [DTQ_W-1:0] dt_q;
   logic [CMP_W-1:0] dtq_x5, period_x2, period_x40;
   logic [XN_W-1:0]  ticks_num;

   assign obs_backwards = t_ff < last_ff;
   assign dt            = t_ff - last_ff;
   assign obs_too_long  = dt > TW'(GAP_CAP_US);
   assign dt_q          = DTQ_W'(dt[GAP_W-1:0]) << PFB;
   assign dtq_x5        = (CMP_W'(dt_q) << 2) + CMP_W'(dt_q);
   assign period_x2     = CMP_W'(period_ff) << 1;
   assign period_x40    = (CMP_W'(period_ff) << 5) + (CMP_W'(period_ff) << 3);
   assign obs_short     = dtq_x5 < period_x2;
   assign obs_long      = CMP_W'(dt_q) > period_x40;
   assign obs_reject    = !grid_valid_ff || obs_backwards || obs_too_long
                          || obs_short || obs_long;
   assign ticks_num     = (XN_W'(dt_q) << 1) + XN_W'(period_ff);

   // blend numerator and denominator: 8*p*n + 2*gap + 5*n over 10*n
   logic [PW+NW-1:0] blend_prod;
   logic [BW-1:0]    blend_num;
   logic [DVS_W-1:0] blend_den;

   assign blend_prod = (PW+NW)'(period_ff) * (PW+NW)'(n_ff);
   assign blend_num  = (BW'(blend_prod) << 3) + (BW'(dtq_ff) << 1)
                       + (BW'(n_ff) << 2) + BW'(n_ff);
   assign blend_den  = (DVS_W'(n_ff) << 3) + (DVS_W'(n_ff) << 1);

   // blended period clamped to the legal range
   logic [PW-1:0] blend_clamped;
   always_comb begin
      priority if (div_quotient < QW'(PERIOD_MIN_Q)) begin
         blend_clamped = PERIOD_MIN_Q;
      end else if (div_quotient > QW'(PERIOD_MAX_Q)) begin
         blend_clamped = PERIOD_MAX_Q;
      end else begin
         blend_clamped = div_quotient[PW-1:0];
      end
   end

   logic [2:0] count_next;
   assign count_next = (count_ff < LOCK_COUNT) ? count_ff + 3'd1 : count_ff;

   // schedule offsets
   logic [CSR_DATA_W-1:0] off_clamp;
   logic [2:0]            r_clamp;
   logic [1:0]            rm1;
   logic [EW-1:0]         retry_span;
   logic [EW-1:0]         extra_next;
   logic [16:0]           tick_span;
   logic [FW-1:0]         unlocked_fire;
   logic [FW-1:0]         ref_next;

   assign off_clamp = (fire_offset_ff > OFFSET_MAX_US) ? OFFSET_MAX_US : fire_offset_ff;

   always_comb begin
      priority if (retry_ticks_ff < RETRY_MIN) begin
         r_clamp = RETRY_MIN;
      end else if (retry_ticks_ff > RETRY_MAX) begin
         r_clamp = RETRY_MAX;
      end else begin
         r_clamp = retry_ticks_ff;
      end
   end

   assign rm1           = 2'(r_clamp - RETRY_MIN);
   assign retry_span    = EW'(period_ff) * EW'(rm1);
   assign extra_next    = (retry_ff ? retry_span : '0) + (EW'(off_clamp) << PFB) + HALF_Q;
   assign tick_span     = 17'(DEFAULT_TICK_US) * 17'(r_clamp);
   assign unlocked_fire = FW'(t_ff) + (retry_ff ? FW'(tick_span) : '0);
   assign ref_next      = retry_ff ? FW'(t_ff) + FW'(RETRY_NUDGE_US) : FW'(t_ff);

   // boundary after the reference time
   logic [QW-1:0] ref_q, anchor_q, phase_bits;
   logic          anchor_after;
   logic [SW-1:0] direct_sum, base_next, phase_sum;

   assign ref_q        = QW'(ref_ff) << PFB;
   assign anchor_q     = QW'(anchor_ff) << PFB;
   assign anchor_after = FW'(anchor_ff) > ref_ff;
   assign direct_sum   = SW'(grid_valid_ff ? anchor_q : ref_q) + SW'(extra_ff);
   assign phase_bits   = QW'(ref_ff - FW'(anchor_ff)) << PFB;
   assign base_next    = SW'(ref_q) + SW'(period_ff) + SW'(extra_ff);
   assign phase_sum    = base_ff - SW'(div_remainder);

   logic ticks_zero;
   assign ticks_zero = (div_quotient == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_type ? ST_SCHED_PREP : ST_OBS_EVAL;
            end
         end
         ST_OBS_EVAL: begin
            state_in = obs_reject ? ST_REPLY : ST_DIV_GO;
         end
         ST_SCHED_PREP: begin
            state_in = align_en_ff ? ST_SCHED_EVAL : ST_REPLY;
         end
         ST_SCHED_EVAL: begin
            state_in = (!grid_valid_ff || anchor_after) ? ST_REPLY : ST_DIV_GO;
         end
         ST_BLEND_OPS: begin
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               if (job_ff == JOB_TICKS && !ticks_zero) begin
                  state_in = ST_BLEND_OPS;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_take   = 1'b0;
      div_start  = 1'b0;
      reply_take = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_take   = 1'b1;
         ST_DIV_GO: div_start  = 1'b1;
         ST_REPLY:  reply_take = !rsp_valid_ff || rsp_ready;
         default:   ;
      endcase
   end

   // datapath next values
   always_comb begin
      job_in        = job_ff;
      grid_valid_in = grid_valid_ff;
      converged_in  = converged_ff;
      period_in     = period_ff;
      anchor_in     = anchor_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      t_in          = t_ff;
      retry_in      = retry_ff;
      dtq_in        = dtq_ff;
      n_in          = n_ff;
      ref_in        = ref_ff;
      extra_in      = extra_ff;
      base_in       = base_ff;
      fire_in       = fire_ff;
      gap_in        = gap_ff;
      dv_steps_in   = dv_steps_ff;
      dv_rem_in     = dv_rem_ff;
      dv_bits_in    = dv_bits_ff;
      dv_den_in     = dv_den_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               t_in     = req_time_us;
               retry_in = req_retry_schedule;
               fire_in  = '0;
               gap_in   = 1'b0;
            end
         end
         ST_OBS_EVAL: begin
            last_in = t_ff;
            if (!grid_valid_ff) begin
               grid_valid_in = 1'b1;
               anchor_in     = t_ff;
            end else if (!obs_reject) begin
               // round gap to whole ticks: (2*gap + p) / (2*p)
               dtq_in      = dt_q;
               job_in      = JOB_TICKS;
               dv_steps_in = CNT_W'(N_STEPS);
               dv_rem_in   = DVS_W'(ticks_num >> N_STEPS);
               dv_bits_in  = QW'(ticks_num[N_STEPS-1:0]) << (QW - N_STEPS);
               dv_den_in   = DVS_W'(period_ff) << 1;
            end
         end
         ST_SCHED_PREP: begin
            if (!align_en_ff) begin
               fire_in = unlocked_fire;
            end else begin
               ref_in   = ref_next;
               extra_in = extra_next;
            end
         end
         ST_SCHED_EVAL: begin
            if (!grid_valid_ff || anchor_after) begin
               fire_in = FW'(direct_sum >> PFB);
            end else begin
               // whole periods between anchor and reference time
               job_in      = JOB_PHASE;
               base_in     = base_next;
               dv_steps_in = CNT_W'(QW);
               dv_rem_in   = '0;
               dv_bits_in  = phase_bits;
               dv_den_in   = DVS_W'(period_ff);
            end
         end
         ST_BLEND_OPS: begin
            job_in      = JOB_BLEND;
            dv_steps_in = CNT_W'(BLEND_STEPS);
            dv_rem_in   = DVS_W'(blend_num >> BLEND_STEPS);
            dv_bits_in  = QW'(blend_num[BLEND_STEPS-1:0]) << (QW - BLEND_STEPS);
            dv_den_in   = blend_den;
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               unique case (job_ff)
                  JOB_TICKS: n_in = div_quotient[NW-1:0];
                  JOB_BLEND: begin
                     period_in    = blend_clamped;
                     anchor_in    = t_ff;
                     count_in     = count_next;
                     converged_in = converged_ff || (count_next >= LOCK_COUNT);
                     gap_in       = 1'b1;
                  end
                  JOB_PHASE: fire_in = FW'(phase_sum >> PFB);
                  default:   ;
               endcase
            end
         end
         default: ;
      endcase
   end

   // result register and configuration writes
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_fire_in   = rsp_fire_ff;
      rsp_period_in = rsp_period_ff;
      rsp_locked_in = rsp_locked_ff;
      rsp_gap_in    = rsp_gap_ff;
      if (reply_take) begin
         rsp_valid_in  = 1'b1;
         rsp_fire_in   = fire_ff;
         rsp_period_in = period_ff;
         rsp_locked_in = converged_ff;
         rsp_gap_in    = gap_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      fire_offset_in = fire_offset_ff;
      retry_ticks_in = retry_ticks_ff;
      align_en_in    = align_en_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FIRE_OFFSET: fire_offset_in = csr_wdata;
            CSR_RETRY_TICKS: retry_ticks_in = csr_wdata[2:0];
            CSR_GRID_ALIGN:  align_en_in    = csr_wdata[0];
            default:         ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fire_offset_ff <= '0;
         retry_ticks_ff <= RETRY_MIN;
         align_en_ff    <= 1'b1;
         grid_valid_ff  <= 1'b0;
         converged_ff   <= 1'b0;
         period_ff      <= PERIOD_RESET_Q;
         anchor_ff      <= '0;
         last_ff        <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fire_offset_ff <= fire_offset_in;
         retry_ticks_ff <= retry_ticks_in;
         align_en_ff    <= align_en_in;
         grid_valid_ff  <= grid_valid_in;
         converged_ff   <= converged_in;
         period_ff      <= period_in;
         anchor_ff      <= anchor_in;
         last_ff        <= last_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      t_ff          <= t_in;
      retry_ff      <= retry_in;
      dtq_ff        <= dtq_in;
      n_ff          <= n_in;
      ref_ff        <= ref_in;
      extra_ff      <= extra_in;
      base_ff       <= base_in;
      fire_ff       <= fire_in;
      gap_ff        <= gap_in;
      dv_steps_ff   <= dv_steps_in;
      dv_rem_ff     <= dv_rem_in;
      dv_bits_ff    <= dv_bits_in;
      dv_den_ff     <= dv_den_in;
      rsp_fire_ff   <= rsp_fire_in;
      rsp_period_ff <= rsp_period_in;
      rsp_locked_ff <= rsp_locked_in;
      rsp_gap_ff    <= rsp_gap_in;
   end

   assign req_ready        = req_take;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fire_time_us = rsp_fire_ff;
   assign rsp_period_q4    = rsp_period_ff;
   assign rsp_locked       = rsp_locked_ff;
   assign rsp_gap_accepted = rsp_gap_ff;

   // divider is never left running when a new word can enter
   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_status.busy)
      else $error("divider busy while idle");

   // lock only after the full count of accepted gaps
   a_lock_count: assert property (@(posedge clock) disable iff (reset)
      converged_ff |-> (count_ff == LOCK_COUNT))
      else $error("locked without enough accepted gaps");

   // period estimate stays inside its clamp range
   a_period_range: assert property (@(posedge clock) disable iff (reset)
      (period_ff >= PERIOD_MIN_Q) && (period_ff <= PERIOD_MAX_Q))
      else $error("period estimate out of range");

   // an accepted gap always leaves a valid grid and a nonzero count
   a_gap_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLY && gap_ff) |-> (grid_valid_ff && count_ff != '0))
      else $error("gap accepted without a grid");

endmodule
